// File: design/line_rasterizer_framebuffer_top_assert.svh
// Assertion macros for the line rasterizer framebuffer top level.
// Expects clk and arst_n in scope where used.
`ifndef LINE_RASTERIZER_FRAMEBUFFER_TOP_ASSERT_SVH
`define LINE_RASTERIZER_FRAMEBUFFER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LRFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LRFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lrfb_pkg.sv
// Shared types and constants for the line rasterizer framebuffer.
// No dependencies; used by lrfb_ctrl, lrfb_dp and the top level.
package lrfb_pkg;

	localparam int FRAME_BYTES = 1024;
	localparam int ADDR_W      = 10;
	localparam int COORD_W     = 9;

	typedef enum logic [1:0] {
		KIND_LINE = 2'd0,
		KIND_READ = 2'd1,
		KIND_FILL = 2'd2
	} kind_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic setup;
		logic order;
		logic plot_rd;
		logic plot_wr;
		logic sweep_wr;
		logic sweep_clear;
		logic read_mem;
		logic rsp_load;
		logic rsp_read;
	} lrfb_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic walk_last;
		logic sweep_last;
	} lrfb_status_t;

endpackage

// File: design/line_rasterizer_framebuffer_top.sv
// Line rasterizer over a 1024-byte page-organized monochrome framebuffer: draw line,
// read byte, fill. After reset the block clears the store in a single sweep and
// accepts no request until it is done. One request is worked at a time; every request
// yields one response, which may wait in the output register while the next request
// is taken. A line walks max(|dx|,|dy|) + 1 pixels (at most 512), each one a read-modify-write
// on the single frame store port; a fill writes one byte per cycle.
`include "line_rasterizer_framebuffer_top_assert.svh"

module line_rasterizer_framebuffer_top import lrfb_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic [1:0]                kind,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic                      ink,
	input  logic [ADDR_W-1:0]         byte_index,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [7:0]                read_byte
);

	lrfb_cmd_t    cmd;
	lrfb_status_t status;

	lrfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.kind      (kind),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lrfb_dp #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.ink        (ink),
		.byte_index (byte_index),
		.status     (status),
		.read_byte  (read_byte)
	);

	// one store access kind per cycle
	`LRFB_ASSERT_NOW(a_store_port, 1'b1, ($onehot0({cmd.plot_rd, cmd.plot_wr, cmd.sweep_wr, cmd.read_mem})), "store port conflict")
	// pixel write always follows its read
	`LRFB_ASSERT_NOW(a_rmw_order, cmd.plot_wr, $past(cmd.plot_rd), "pixel write without read")
	// a waiting response is never overwritten
	`LRFB_ASSERT_NOW(a_no_overwrite, cmd.rsp_load, !(rsp_valid && rsp_stall), "response overwritten")
	// one request in flight at a time
	`LRFB_ASSERT_NEXT(a_single_req, (cmd_valid && !cmd_stall), cmd_stall, "second request taken early")

endmodule

// File: design/lrfb_ctrl.sv
// Sequencer for the line rasterizer framebuffer.
// Depends on lrfb_pkg; drives the command struct for lrfb_dp.
module lrfb_ctrl import lrfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_stall,
	input  logic [1:0]   kind,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	input  lrfb_status_t status,
	output lrfb_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_ORDER,
		ST_PLOT_RD,
		ST_PLOT_WR,
		ST_SWEEP,
		ST_READ_MEM,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   is_read_q, is_read_d;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		is_read_d = is_read_q;
		cmd.rsp_read = is_read_q;
		unique case (state_q)
			ST_CLEAR: begin
				// power-up sweep writes zeros over the whole store
				cmd.sweep_wr    = 1'b1;
				cmd.sweep_clear = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd.accept = 1'b1;
					is_read_d  = 1'b0;
					unique case (kind_t'(kind))
						KIND_LINE: state_d = ST_SETUP;
						KIND_READ: begin
							state_d   = ST_READ_MEM;
							is_read_d = 1'b1;
						end
						KIND_FILL: state_d = ST_SWEEP;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_ORDER;
			end
			ST_ORDER: begin
				cmd.order = 1'b1;
				state_d   = ST_PLOT_RD;
			end
			ST_PLOT_RD: begin
				cmd.plot_rd = 1'b1;
				state_d     = ST_PLOT_WR;
			end
			ST_PLOT_WR: begin
				cmd.plot_wr = 1'b1;
				state_d     = status.walk_last ? ST_FINISH : ST_PLOT_RD;
			end
			ST_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_READ_MEM: begin
				cmd.read_mem = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
			is_read_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			is_read_q <= is_read_d;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/lrfb_dp.sv
// Datapath: Bresenham walk registers, pixel addressing and the frame store.
// Depends on lrfb_pkg; sequenced by lrfb_ctrl through lrfb_cmd_t.
module lrfb_dp import lrfb_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lrfb_cmd_t                  cmd,
	input  logic signed [COORD_W-1:0]  start_x,
	input  logic signed [COORD_W-1:0]  start_y,
	input  logic signed [COORD_W-1:0]  end_x,
	input  logic signed [COORD_W-1:0]  end_y,
	input  logic                       ink,
	input  logic [ADDR_W-1:0]          byte_index,
	output lrfb_status_t               status,
	output logic [7:0]                 read_byte
);

	localparam logic [9:0]  PW10 = 10'(PANEL_WIDTH);
	localparam logic [9:0]  PH10 = 10'(PANEL_HEIGHT);
	localparam logic [15:0] PW16 = 16'(PANEL_WIDTH);
	localparam logic [15:0] FB16 = 16'(FRAME_BYTES);

	logic [7:0] mem [FRAME_BYTES];

	logic signed [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [COORD_W-1:0] a0_q, b0_q, a1_q, b1_q;
	logic                      ink_q, steep_q, step_up_q, on_q;
	logic [ADDR_W-1:0]         index_q, addr_q, sweep_q;
	logic signed [9:0]         cur_a_q, cur_b_q;
	logic [8:0]                cnt_q, dx_q, dy_q;
	logic signed [10:0]        err_q;
	logic [2:0]                bit_q;
	logic [7:0]                rdata_q, read_byte_q;

	// setup: steepness test
	logic signed [9:0] ddx, ddy;
	logic [9:0]        adx, ady;
	logic              steep;
	assign ddx   = 10'(x1_q) - 10'(x0_q);
	assign ddy   = 10'(y1_q) - 10'(y0_q);
	assign adx   = ddx[9] ? -ddx : ddx;
	assign ady   = ddy[9] ? -ddy : ddy;
	assign steep = ady > adx;

	// order: endpoints sorted along the major axis
	logic                      swap;
	logic signed [COORD_W-1:0] lo_a, hi_a, lo_b, hi_b;
	logic signed [9:0]         da, db;
	logic [9:0]                adb;
	assign swap = a0_q > a1_q;
	assign lo_a = swap ? a1_q : a0_q;
	assign hi_a = swap ? a0_q : a1_q;
	assign lo_b = swap ? b1_q : b0_q;
	assign hi_b = swap ? b0_q : b1_q;
	assign da   = 10'(hi_a) - 10'(lo_a);
	assign db   = 10'(hi_b) - 10'(lo_b);
	assign adb  = db[9] ? -db : db;

	// pixel under the walk
	logic signed [9:0] px, py;
	logic [15:0]       pix_addr;
	logic              pix_on;
	assign px       = steep_q ? cur_b_q : cur_a_q;
	assign py       = steep_q ? cur_a_q : cur_b_q;
	assign pix_addr = 16'(py[8:3]) * PW16 + 16'(px[8:0]);
	assign pix_on   = !px[9] && !py[9] && (px < PW10) && (py < PH10) && (pix_addr < FB16);

	// step
	logic signed [10:0] err_dec;
	assign err_dec = err_q - 11'(dy_q);

	// store port selection
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [7:0]        wdata, mask;
	assign mask    = 8'd1 << bit_q;
	assign rd_en   = cmd.read_mem || (cmd.plot_rd && pix_on);
	assign rd_addr = cmd.read_mem ? index_q : pix_addr[ADDR_W-1:0];
	assign wr_en   = cmd.sweep_wr || (cmd.plot_wr && on_q);
	assign wr_addr = cmd.sweep_wr ? sweep_q : addr_q;
	always_comb begin
		if (cmd.sweep_wr) begin
			wdata = (cmd.sweep_clear || !ink_q) ? 8'h00 : 8'hFF;
		end else if (ink_q) begin
			wdata = rdata_q | mask;
		end else begin
			wdata = rdata_q & ~mask;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x0_q    <= start_x;
			y0_q    <= start_y;
			x1_q    <= end_x;
			y1_q    <= end_y;
			ink_q   <= ink;
			index_q <= byte_index;
		end
		if (cmd.setup) begin
			steep_q <= steep;
			a0_q    <= steep ? y0_q : x0_q;
			b0_q    <= steep ? x0_q : y0_q;
			a1_q    <= steep ? y1_q : x1_q;
			b1_q    <= steep ? x1_q : y1_q;
		end
		if (cmd.order) begin
			cur_a_q   <= 10'(lo_a);
			cur_b_q   <= 10'(lo_b);
			dx_q      <= da[8:0];
			cnt_q     <= da[8:0];
			dy_q      <= adb[8:0];
			err_q     <= 11'(da[8:1]);
			step_up_q <= lo_b < hi_b;
		end
		if (cmd.plot_rd) begin
			on_q   <= pix_on;
			addr_q <= pix_addr[ADDR_W-1:0];
			bit_q  <= py[2:0];
		end
		if (cmd.plot_wr) begin
			cur_a_q <= cur_a_q + 10'sd1;
			cnt_q   <= cnt_q - 9'd1;
			if (err_dec < 0) begin
				err_q   <= err_dec + 11'(dx_q);
				cur_b_q <= step_up_q ? cur_b_q + 10'sd1 : cur_b_q - 10'sd1;
			end else begin
				err_q <= err_dec;
			end
		end
		if (cmd.rsp_load) begin
			read_byte_q <= cmd.rsp_read ? rdata_q : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_q <= sweep_q + ADDR_W'(1);
		end
	end

	assign status.walk_last  = (cnt_q == 9'd0);
	assign status.sweep_last = &sweep_q;
	assign read_byte         = read_byte_q;

endmodule

// File: tb/sv/lrfb_frame_checker.sv
`timescale 1ns / 100ps
// Checker for the line rasterizer framebuffer: watches the request and response channels,
// mirrors the frame store to predict read_byte, and counts mismatches.
// Depends on lrfb_pkg.
module lrfb_frame_checker import lrfb_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  logic                      cmd_stall,
	input  logic [1:0]                kind,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic                      ink,
	input  logic [ADDR_W-1:0]         byte_index,
	input  logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  logic [7:0]                read_byte,
	output int                        fail_count,
	output int                        outstanding
);

	logic [7:0] frame_mirror [FRAME_BYTES];
	logic [7:0] expected_read_bytes [$];
	logic [7:0] expected_byte;
	int         response_count;

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	// off-panel pixels are dropped; coordinates stay signed, no 8-bit wrap
	function automatic void plot_pixel(int x, int y, logic ink_bit);
		int         addr;
		logic [7:0] mask;
		if (x < 0 || y < 0 || x >= PANEL_WIDTH || y >= PANEL_HEIGHT)
			return;
		addr = (y / 8) * PANEL_WIDTH + x;
		if (addr >= FRAME_BYTES)
			return;
		mask = 8'(1 << (y % 8));
		if (ink_bit)
			frame_mirror[addr] = frame_mirror[addr] | mask;
		else
			frame_mirror[addr] = frame_mirror[addr] & ~mask;
	endfunction

	function automatic void rasterize_line(int x0, int y0, int x1, int y1, logic ink_bit);
		bit steep;
		int t, dx, dy, err, ystep;
		steep = magnitude(y1 - y0) > magnitude(x1 - x0);
		if (steep) begin
			t = x0; x0 = y0; y0 = t;
			t = x1; x1 = y1; y1 = t;
		end
		if (x0 > x1) begin
			t = x0; x0 = x1; x1 = t;
			t = y0; y0 = y1; y1 = t;
		end
		dx = x1 - x0;
		dy = magnitude(y1 - y0);
		err = dx / 2;
		ystep = (y0 < y1) ? 1 : -1;
		while (x0 <= x1) begin
			if (steep)
				plot_pixel(y0, x0, ink_bit);
			else
				plot_pixel(x0, y0, ink_bit);
			err -= dy;
			if (err < 0) begin
				y0 += ystep;
				err += dx;
			end
			x0++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++)
				frame_mirror[i] = 8'h00;
			expected_read_bytes.delete();
			fail_count = 0;
			outstanding = 0;
			response_count = 0;
		end else begin
			// response side first: a response never belongs to a request taken this edge
			if (rsp_valid && !rsp_stall) begin
				if (expected_read_bytes.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: response %0d with no request outstanding, read_byte %02h",
							$time, response_count, read_byte);
					fail_count++;
				end else begin
					expected_byte = expected_read_bytes.pop_front();
					if (read_byte !== expected_byte) begin
						if (fail_count < 10)
							$display("%0t: response %0d read_byte expected %02h, got %02h",
								$time, response_count, expected_byte, read_byte);
						fail_count++;
					end
				end
				response_count++;
			end
			if (cmd_valid && !cmd_stall) begin
				expected_byte = 8'h00;
				case (kind)
					KIND_LINE: rasterize_line(int'(start_x), int'(start_y), int'(end_x),
						int'(end_y), ink);
					KIND_READ: expected_byte = frame_mirror[byte_index];
					KIND_FILL: begin
						for (int i = 0; i < FRAME_BYTES; i++)
							frame_mirror[i] = {8{ink}};
					end
					default: ;
				endcase
				expected_read_bytes.push_back(expected_byte);
			end
			outstanding = expected_read_bytes.size();
		end
	end

endmodule

// File: tb/sv/line_rasterizer_framebuffer_top_test.sv
`timescale 1ns / 100ps
// Testbench top for line_rasterizer_framebuffer_top: clock, reset, request stimulus,
// response stalls and the verdict. Checking is done by lrfb_frame_checker; uses lrfb_pkg.
module line_rasterizer_framebuffer_top_test;
	import lrfb_pkg::*;

	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 290;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_LIMIT = 40000;
	localparam int SEND_IDLE_PCT [4] = '{0, 80, 0, 18};
	localparam int RSP_STALL_PCT [4] = '{0, 0, 80, 18};

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic                      ink;
		logic [ADDR_W-1:0]         byte_index;
	} lrfb_request_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_stall;
	logic [1:0]                kind;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic                      ink;
	logic [ADDR_W-1:0]         byte_index;
	logic                      rsp_valid;
	logic                      rsp_stall;
	logic [7:0]                read_byte;
	int                        fail_count;
	int                        outstanding;

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int last_sx, last_sy, last_ex, last_ey;

	line_rasterizer_framebuffer_top #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.kind      (kind),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.ink       (ink),
		.byte_index(byte_index),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.read_byte (read_byte)
	);

	lrfb_frame_checker #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_checker (.*);

	always #5 clk = ~clk;

	// response side: one long hold-off on request, otherwise random stalls
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				rsp_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			rsp_stall = (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
		end
	end

	initial begin
		#100_000_000;
		$display("line_rasterizer_framebuffer_top_test failed");
		$finish;
	end

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic lrfb_request_t line_req(int sx, int sy, int ex, int ey, logic ink_bit);
		lrfb_request_t req;
		req = '0;
		req.kind = KIND_LINE;
		req.start_x = COORD_W'(sx);
		req.start_y = COORD_W'(sy);
		req.end_x = COORD_W'(ex);
		req.end_y = COORD_W'(ey);
		req.ink = ink_bit;
		return req;
	endfunction

	function automatic lrfb_request_t read_req(int idx);
		lrfb_request_t req;
		req = '0;
		req.kind = KIND_READ;
		req.byte_index = ADDR_W'(idx);
		return req;
	endfunction

	function automatic lrfb_request_t fill_req(logic ink_bit);
		lrfb_request_t req;
		req = '0;
		req.kind = KIND_FILL;
		req.ink = ink_bit;
		return req;
	endfunction

	// Short lines near the panel, lines across the panel and reads aimed at the last line drawn;
	// the rest are full-range lines, random reads, fills and unused kinds.
	function automatic lrfb_request_t random_request();
		lrfb_request_t req;
		int pick, shape, lx, ly;
		req.kind = 2'($urandom);
		req.start_x = COORD_W'($urandom);
		req.start_y = COORD_W'($urandom);
		req.end_x = COORD_W'($urandom);
		req.end_y = COORD_W'($urandom);
		req.byte_index = ADDR_W'($urandom);
		req.ink = ($urandom_range(3) != 0);
		pick = $urandom_range(99);
		if (pick < 42) begin
			req.kind = KIND_LINE;
			shape = $urandom_range(9);
			if (shape < 6) begin
				lx = rand_between(-8, PANEL_WIDTH + 7);
				ly = rand_between(-8, PANEL_HEIGHT + 7);
				req.start_x = COORD_W'(lx);
				req.start_y = COORD_W'(ly);
				req.end_x = COORD_W'(lx + rand_between(-24, 24));
				req.end_y = COORD_W'(ly + rand_between(-24, 24));
			end else if (shape < 9) begin
				req.start_x = COORD_W'(rand_between(-16, PANEL_WIDTH + 15));
				req.start_y = COORD_W'(rand_between(-16, PANEL_HEIGHT + 15));
				req.end_x = COORD_W'(rand_between(-16, PANEL_WIDTH + 15));
				req.end_y = COORD_W'(rand_between(-16, PANEL_HEIGHT + 15));
			end
			last_sx = req.start_x;
			last_sy = req.start_y;
			last_ex = req.end_x;
			last_ey = req.end_y;
		end else if (pick < 90) begin
			req.kind = KIND_READ;
			if ($urandom_range(1) == 1) begin
				lx = $urandom_range(1) ? last_sx : last_ex;
				ly = (lx == last_sx) ? last_sy : last_ey;
				lx += rand_between(-1, 1);
				if (lx >= 0 && ly >= 0 && lx < PANEL_WIDTH && ly < PANEL_HEIGHT)
					req.byte_index = ADDR_W'((ly / 8) * PANEL_WIDTH + lx);
			end
		end else if (pick < 94) begin
			req.kind = KIND_FILL;
		end else if (pick < 97) begin
			req.kind = KIND_UNUSED;
		end else begin
			req.kind = KIND_LINE;
		end
		return req;
	endfunction

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic send_request(input lrfb_request_t req);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		kind = req.kind;
		start_x = req.start_x;
		start_y = req.start_y;
		end_x = req.end_x;
		end_y = req.end_y;
		ink = req.ink;
		byte_index = req.byte_index;
		cmd_valid = 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		lrfb_request_t req;
		int waited;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		kind = KIND_LINE;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		ink = 1'b0;
		byte_index = '0;
		last_sx = 0;
		last_sy = 0;
		last_ex = 0;
		last_ey = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(read_req(0));
		send_request(line_req(0, 0, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 1'b1));
		send_request(read_req(0));
		send_request(read_req(FRAME_BYTES - 1));
		send_request(line_req(5, 5, 5, 5, 1'b1));
		send_request(read_req(5));
		send_request(line_req(-256, 10, 255, 10, 1'b1));
		send_request(read_req(PANEL_WIDTH + 64));
		send_request(line_req(20, -256, 20, 255, 1'b1));
		send_request(read_req(3 * PANEL_WIDTH + 20));
		send_request(line_req(255, 255, -256, -256, 1'b0));
		send_request(line_req(-256, 255, 255, -256, 1'b1));
		// would land on the panel if coordinates wrapped to 8 bits
		send_request(line_req(-200, -200, -190, -190, 1'b1));
		send_request(line_req(100, 40, 10, 3, 1'b1));
		send_request(read_req(4 * PANEL_WIDTH + 55));
		req = random_request();
		req.kind = KIND_UNUSED;
		send_request(req);
		send_request(fill_req(1'b1));
		send_request(line_req(0, 0, PANEL_WIDTH - 1, 0, 1'b0));
		send_request(read_req(0));
		send_request(read_req(FRAME_BYTES - 1));
		send_request(fill_req(1'b0));
		send_request(read_req(512));
		send_request(line_req(3, 60, 7, -2, 1'b1));
		send_request(read_req(7 * PANEL_WIDTH + 3));

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = SEND_IDLE_PCT[phase];
			rsp_stall_pct = RSP_STALL_PCT[phase];
			// long response hold-off so the block backs up into the request side
			if (phase == 0)
				hold_request = 1'b1;
			repeat (ITEMS_PER_PHASE)
				send_request(random_request());
		end
		cmd_valid = 1'b0;

		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (16) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("line_rasterizer_framebuffer_top_test passed");
		else
			$display("line_rasterizer_framebuffer_top_test failed");
		$finish;
	end

endmodule
